// ===== src/rrqs_pkg.sv =====
// shared types and codes for the round-robin quantum scheduler
`timescale 1ns / 1ps

package rrqs_pkg;

	localparam int unsigned ID_W     = 5;
	localparam int unsigned TIME_W   = 16;
	localparam int unsigned STATUS_W = 2;
	localparam int unsigned ENTRY_W  = ID_W + TIME_W;

	// action codes
	localparam logic ACT_LOAD = 1'b0;
	localparam logic ACT_RUN  = 1'b1;

	// status codes
	localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd2;

	typedef enum logic [1:0] {
		CS_IDLE,
		CS_EXEC,
		CS_INS
	} ctrl_state_t;

	// controller to datapath
	typedef struct packed {
		logic capture;
		logic exec;
		logic ins;
		logic publish;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic need_ins;
	} dp_stat_t;

endpackage

// ===== src/rrqs_in_if.sv =====
// input channel: one scheduler request word
`timescale 1ns / 1ps

interface rrqs_in_if import rrqs_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              action;
	logic              new_valid;
	logic [TIME_W-1:0] new_duration;

	modport source (output valid, action, new_valid, new_duration, input ready);
	modport sink (input valid, action, new_valid, new_duration, output ready);
endinterface

// ===== src/rrqs_out_if.sv =====
// output channel: one scheduler result word
`timescale 1ns / 1ps

interface rrqs_out_if import rrqs_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [ID_W-1:0]     ran_id;
	logic                completed;
	logic [ID_W-1:0]     added_id;
	logic [ID_W-1:0]     live_count;
	logic [STATUS_W-1:0] status;

	modport source (output valid, ran_id, completed, added_id, live_count, status,
		input ready);
	modport sink (input valid, ran_id, completed, added_id, live_count, status,
		output ready);
endinterface

// ===== src/round_robin_quantum_scheduler.sv =====
// top level of the round-robin quantum scheduler
`timescale 1ns / 1ps

// Round-robin scheduler with a fixed time quantum. The queue holds up to
// QUEUE_DEPTH processes in a ring inside one ram, each entry a 5-bit process
// number and 16 bits of remaining time. A load word appends a process at the
// tail; a run word charges the head process one quantum, retires it when its
// remaining time is at or below the quantum, otherwise moves it to the tail,
// and may then put a new process in front of the head. New processes are
// numbered live count plus one. Every request word gives exactly one result
// word. Timing: a load word, an empty run and a run without insert pass
// through the accepting step (which also issues the registered ram read of
// the head entry) and an execute step that registers the result word, after
// which the block is idle and can take the next word. A run with insert adds
// an insert step that registers the result, because the requeued entry and
// the new head entry both go through the single ram write port. The result
// sits in an output register, so the next request is accepted while the
// previous result waits; a step stalls only when its own result would meet a
// still-untaken word. The queue ram needs no clearing after reset: only live
// entries are ever used. quantum resets to 1 and is written through
// cfg_we/cfg_wdata; the user must write it only while the block is idle,
// the block itself does not enforce this.
module round_robin_quantum_scheduler import rrqs_pkg::*; #(
	parameter int unsigned QUEUE_DEPTH = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [TIME_W-1:0] cfg_wdata,
	rrqs_in_if.sink           sched_in,
	rrqs_out_if.source        sched_out
);

	// command and status between sequencer and datapath
	dp_cmd_t  cmd;
	dp_stat_t stat;

	// sequencer: owns the handshakes and the output word valid
	rrqs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (sched_in.valid),
		.in_ready  (sched_in.ready),
		.out_valid (sched_out.valid),
		.out_ready (sched_out.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// datapath: queue ram, pointers, quantum register, result word register
	rrqs_dp #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_wdata       (cfg_wdata),
		.cmd             (cmd),
		.stat            (stat),
		.in_action       (sched_in.action),
		.in_new_valid    (sched_in.new_valid),
		.in_new_duration (sched_in.new_duration),
		.ran_id          (sched_out.ran_id),
		.completed       (sched_out.completed),
		.added_id        (sched_out.added_id),
		.live_count      (sched_out.live_count),
		.status          (sched_out.status)
	);

endmodule

// ===== src/rrqs_ram.sv =====
// generic single-write, single-read ram with registered read
`timescale 1ns / 1ps

module rrqs_ram #(
	parameter int unsigned WIDTH = 21,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

// ===== src/rrqs_ctrl.sv =====
// scheduler sequencer: handshakes and step commands
`timescale 1ns / 1ps

module rrqs_ctrl import rrqs_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	output logic     out_valid,
	input  logic     out_ready,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);

	ctrl_state_t state_q, state_d;
	logic        out_valid_q;
	logic        out_free;

	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			CS_IDLE: begin
				if (in_valid) state_d = CS_EXEC;
			end
			CS_EXEC: begin
				if (out_free) state_d = stat.need_ins ? CS_INS : CS_IDLE;
			end
			CS_INS: begin
				if (out_free) state_d = CS_IDLE;
			end
			default: state_d = CS_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			CS_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
			end
			CS_EXEC: begin
				cmd.exec    = out_free;
				cmd.publish = out_free && !stat.need_ins;
			end
			CS_INS: begin
				cmd.ins     = out_free;
				cmd.publish = out_free;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= CS_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.publish) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

	// a result word is never overwritten before it is taken
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.publish |-> (!out_valid_q || out_ready))
		else $error("result word overwritten");

	// an insert step only ever follows an exec step
	a_ins_after_exec: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == CS_INS) |-> ($past(state_q) == CS_EXEC || $past(state_q) == CS_INS))
		else $error("insert step without a run step");

endmodule

// ===== src/rrqs_dp.sv =====
// scheduler datapath: queue ram, head pointer, live count, result register
`timescale 1ns / 1ps

module rrqs_dp import rrqs_pkg::*; #(
	parameter int unsigned QUEUE_DEPTH = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [TIME_W-1:0]   cfg_wdata,
	input  dp_cmd_t             cmd,
	output dp_stat_t            stat,
	input  logic                in_action,
	input  logic                in_new_valid,
	input  logic [TIME_W-1:0]   in_new_duration,
	output logic [ID_W-1:0]     ran_id,
	output logic                completed,
	output logic [ID_W-1:0]     added_id,
	output logic [ID_W-1:0]     live_count,
	output logic [STATUS_W-1:0] status
);

	localparam int unsigned PW  = $clog2(QUEUE_DEPTH);
	localparam int unsigned CW  = $clog2(QUEUE_DEPTH + 1);
	localparam int unsigned CW1 = CW + 1;
	localparam logic [CW-1:0]  DEPTH_C = CW'(QUEUE_DEPTH);
	localparam logic [CW1-1:0] DEPTH_X = CW1'(QUEUE_DEPTH);
	localparam logic [PW-1:0]  LAST_P  = PW'(QUEUE_DEPTH - 1);

	logic [PW-1:0]       head_q, head_d;
	logic [CW-1:0]       count_q, count_d;
	logic [TIME_W-1:0]   quantum_q;
	logic                act_q, newv_q;
	logic [TIME_W-1:0]   dur_q;
	logic [ID_W-1:0]     run_id_q;
	logic                run_done_q;
	logic [ID_W-1:0]     o_ran_id_q, o_added_id_q, o_live_q;
	logic                o_completed_q;
	logic [STATUS_W-1:0] o_status_q;

	logic                wr_en;
	logic [PW-1:0]       wr_addr;
	logic [ENTRY_W-1:0]  wr_data, rd_data;

	logic [ID_W-1:0]     head_id;
	logic [TIME_W-1:0]   head_rem;
	logic                fits, full, empty;
	logic [CW1-1:0]      tail_sum, nid_w;
	logic [PW-1:0]       tail, head_inc, head_dec;
	logic [ID_W-1:0]     nid;

	logic [ID_W-1:0]     r_ran_id, r_added_id;
	logic                r_completed;
	logic [STATUS_W-1:0] r_status;

	rrqs_ram #(.WIDTH(ENTRY_W), .DEPTH(QUEUE_DEPTH)) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (head_q),
		.rd_data (rd_data)
	);

	assign head_id  = rd_data[ENTRY_W-1:TIME_W];
	assign head_rem = rd_data[TIME_W-1:0];
	assign fits     = head_rem <= quantum_q;
	assign full     = count_q == DEPTH_C;
	assign empty    = count_q == '0;
	assign tail_sum = CW1'(head_q) + CW1'(count_q);
	assign tail     = (tail_sum >= DEPTH_X) ? PW'(tail_sum - DEPTH_X) : PW'(tail_sum);
	assign head_inc = (head_q == LAST_P) ? '0 : head_q + 1'b1;
	assign head_dec = (head_q == '0) ? LAST_P : head_q - 1'b1;
	assign nid_w    = CW1'(count_q) + 1'b1;
	assign nid      = ID_W'(nid_w);

	always_comb begin
		head_d        = head_q;
		count_d       = count_q;
		wr_en         = 1'b0;
		wr_addr       = tail;
		wr_data       = {nid, dur_q};
		stat.need_ins = 1'b0;
		r_ran_id      = '0;
		r_completed   = 1'b0;
		r_added_id    = '0;
		r_status      = STAT_OK;
		if (cmd.ins) begin
			// new process goes in front of the head
			wr_en       = 1'b1;
			wr_addr     = head_dec;
			head_d      = head_dec;
			count_d     = count_q + 1'b1;
			r_ran_id    = run_id_q;
			r_completed = run_done_q;
			r_added_id  = nid;
		end else if (act_q == ACT_LOAD) begin
			if (full) begin
				r_status = STAT_FULL;
			end else begin
				wr_en      = cmd.exec;
				count_d    = count_q + 1'b1;
				r_added_id = nid;
			end
		end else if (empty) begin
			r_status = STAT_EMPTY;
		end else begin
			// charge the head one quantum; requeue at the tail if unfinished
			head_d      = head_inc;
			r_ran_id    = head_id;
			r_completed = fits;
			if (fits) begin
				count_d = count_q - 1'b1;
			end else begin
				wr_en   = cmd.exec;
				wr_data = {head_id, head_rem - quantum_q};
			end
			if (newv_q) begin
				if (!fits && full) r_status = STAT_FULL;
				else stat.need_ins = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q    <= '0;
			count_q   <= '0;
			quantum_q <= TIME_W'(1);
		end else begin
			if (cfg_we) quantum_q <= cfg_wdata;
			if (cmd.exec || cmd.ins) begin
				head_q  <= head_d;
				count_q <= count_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			act_q  <= in_action;
			newv_q <= in_new_valid;
			dur_q  <= in_new_duration;
		end
		if (cmd.exec) begin
			run_id_q   <= r_ran_id;
			run_done_q <= r_completed;
		end
		if (cmd.publish) begin
			o_ran_id_q    <= r_ran_id;
			o_completed_q <= r_completed;
			o_added_id_q  <= r_added_id;
			o_live_q      <= ID_W'(count_d);
			o_status_q    <= r_status;
		end
	end

	assign ran_id     = o_ran_id_q;
	assign completed  = o_completed_q;
	assign added_id   = o_added_id_q;
	assign live_count = o_live_q;
	assign status     = o_status_q;

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= DEPTH_C)
		else $error("live count beyond queue depth");

	a_ins_grows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ins |=> (count_q == $past(count_q) + 1'b1) && (head_q == $past(head_dec)))
		else $error("insert did not add at the head");

endmodule

// ===== sim/round_robin_quantum_scheduler_tb.sv =====
// self-checking testbench for the round-robin quantum scheduler
`timescale 1ns / 1ps

module round_robin_quantum_scheduler_tb import rrqs_pkg::*; ();

	localparam int unsigned DEPTH         = 16;
	localparam int unsigned ITEMS         = 2000;
	localparam int unsigned PHASE_ITEMS   = ITEMS / 6;
	localparam int unsigned BURST_LEN     = 40;
	localparam int unsigned REPORT_LIMIT  = 10;
	localparam int unsigned HOLD_CYCLES   = 300;
	localparam int unsigned SETTLE_CYCLES = 8;
	localparam int unsigned IDLE_PCT      = 31;

	// one result word as the block reports it
	typedef struct packed {
		logic [ID_W-1:0]     ran_id;
		logic                completed;
		logic [ID_W-1:0]     added_id;
		logic [ID_W-1:0]     live_count;
		logic [STATUS_W-1:0] status;
	} sched_result_t;

	// balance of load and run words within one burst of random traffic
	typedef enum logic [1:0] {
		MIX_FILL,
		MIX_DRAIN,
		MIX_EVEN
	} burst_mix_t;

	// scheduler shadow: ring of processes, predicted result words, tallies
	class sched_scoreboard;
		logic [ID_W-1:0]   ring_id [DEPTH];
		logic [TIME_W-1:0] ring_time [DEPTH];
		int unsigned       head;
		int unsigned       count;
		logic [TIME_W-1:0] quantum;
		sched_result_t     expected_results [$];
		int unsigned       failures;
		int unsigned       n_checked;
		int unsigned       n_loads;
		int unsigned       n_runs;
		int unsigned       n_inserts;
		int unsigned       n_done;
		int unsigned       n_full;
		int unsigned       n_empty;

		function new();
			head      = 0;
			count     = 0;
			quantum   = 1;
			failures  = 0;
			n_checked = 0;
			n_loads   = 0;
			n_runs    = 0;
			n_inserts = 0;
			n_done    = 0;
			n_full    = 0;
			n_empty   = 0;
		endfunction

		function void set_quantum(logic [TIME_W-1:0] q);
			quantum = q;
		endfunction

		function int unsigned pending();
			return expected_results.size();
		endfunction

		function void report(string msg);
			failures++;
			if (failures <= REPORT_LIMIT)
				$display("[%0t] %s", $realtime, msg);
		endfunction

		// advance the shadow ring by one accepted request word
		function void note_request(logic act, logic ins, logic [TIME_W-1:0] dur);
			sched_result_t     r;
			int unsigned       slot;
			logic [ID_W-1:0]   id;
			logic [TIME_W-1:0] rem;
			r = '0;
			if (act == ACT_LOAD) begin
				n_loads++;
				if (count >= DEPTH) begin
					r.status = STAT_FULL;
				end else begin
					slot = (head + count) % DEPTH;
					ring_id[slot]   = ID_W'(count + 1);
					ring_time[slot] = dur;
					count++;
					r.added_id = ID_W'(count);
				end
			end else if (count == 0) begin
				n_runs++;
				r.status = STAT_EMPTY;
			end else begin
				n_runs++;
				id  = ring_id[head];
				rem = ring_time[head];
				r.ran_id = id;
				head = (head + 1) % DEPTH;
				count--;
				if (rem <= quantum) begin
					r.completed = 1'b1;
				end else begin
					slot = (head + count) % DEPTH;
					ring_id[slot]   = id;
					ring_time[slot] = rem - quantum;
					count++;
				end
				if (ins) begin
					if (count >= DEPTH) begin
						r.status = STAT_FULL;
					end else begin
						head = (head + DEPTH - 1) % DEPTH;
						ring_id[head]   = ID_W'(count + 1);
						ring_time[head] = dur;
						count++;
						r.added_id = ID_W'(count);
						n_inserts++;
					end
				end
			end
			r.live_count = ID_W'(count);
			if (r.completed)
				n_done++;
			if (r.status == STAT_FULL)
				n_full++;
			if (r.status == STAT_EMPTY)
				n_empty++;
			expected_results.push_back(r);
		endfunction

		// compare one taken result word with the oldest prediction
		function void check_result(sched_result_t got);
			sched_result_t want;
			string         bad;
			n_checked++;
			if (expected_results.size() == 0) begin
				report($sformatf("word %0d arrived with nothing expected: ran=%0d done=%0b added=%0d live=%0d status=%0d",
					n_checked, got.ran_id, got.completed, got.added_id, got.live_count,
					got.status));
				return;
			end
			want = expected_results.pop_front();
			bad  = "";
			if (got.ran_id !== want.ran_id)
				bad = {bad, " ran_id"};
			if (got.completed !== want.completed)
				bad = {bad, " completed"};
			if (got.added_id !== want.added_id)
				bad = {bad, " added_id"};
			if (got.live_count !== want.live_count)
				bad = {bad, " live_count"};
			if (got.status !== want.status)
				bad = {bad, " status"};
			if (bad != "")
				report($sformatf({"word %0d wrong%s: expected ran=%0d done=%0b added=%0d ",
					"live=%0d status=%0d, got ran=%0d done=%0b added=%0d live=%0d status=%0d"},
					n_checked, bad, want.ran_id, want.completed, want.added_id,
					want.live_count, want.status, got.ran_id, got.completed, got.added_id,
					got.live_count, got.status));
		endfunction
	endclass

	logic              clk;
	logic              arst_n;
	logic              cfg_we;
	logic [TIME_W-1:0] cfg_wdata;

	// steady: no idling on either side; hold_req: ask the receiver for a long hold-off
	logic        steady;
	logic        hold_req;
	int unsigned quanta_used;

	sched_scoreboard sb = new();

	rrqs_in_if  sched_in ();
	rrqs_out_if sched_out ();

	round_robin_quantum_scheduler #(
		.QUEUE_DEPTH(DEPTH)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.sched_in (sched_in),
		.sched_out(sched_out)
	);

	// 2 ns clock
	initial clk = 1'b0;
	always #1 clk = ~clk;

	// hard stop in case the block hangs
	initial begin
		#1_000_000;
		$display("FAILURE");
		$finish;
	end

	// receiver: random ready at the falling edge, long hold-off on request
	initial begin
		sched_out.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				// block the result side long enough that the input stalls too
				hold_req = 1'b0;
				sched_out.ready = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			sched_out.ready = steady || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	// result monitor: every taken word is checked at the rising edge
	always @(posedge clk) begin : result_monitor
		sched_result_t got;
		if (arst_n && sched_out.valid && sched_out.ready) begin
			got.ran_id     = sched_out.ran_id;
			got.completed  = sched_out.completed;
			got.added_id   = sched_out.added_id;
			got.live_count = sched_out.live_count;
			got.status     = sched_out.status;
			sb.check_result(got);
		end
	end

	// offer one request word, with random idle cycles ahead of it
	task automatic send_word(input logic act, input logic ins, input logic [TIME_W-1:0] dur);
		while (!steady && ($urandom_range(99) < IDLE_PCT)) begin
			sched_in.valid = 1'b0;
			@(negedge clk);
		end
		sched_in.valid        = 1'b1;
		sched_in.action       = act;
		sched_in.new_valid    = ins;
		sched_in.new_duration = dur;
		@(posedge clk);
		while (!sched_in.ready)
			@(posedge clk);
		sb.note_request(act, ins, dur);
		@(negedge clk);
	endtask

	// stop offering and wait until every predicted word has been taken
	task automatic wait_results_drained();
		sched_in.valid = 1'b0;
		while (sb.pending() != 0)
			@(negedge clk);
	endtask

	// quantum change only with the block idle
	task automatic write_quantum(input logic [TIME_W-1:0] q);
		wait_results_drained();
		repeat (SETTLE_CYCLES) @(negedge clk);
		cfg_we    = 1'b1;
		cfg_wdata = q;
		sb.set_quantum(q);
		@(negedge clk);
		cfg_we = 1'b0;
		quanta_used++;
	endtask

	// one random request word, durations scaled to the current quantum
	task automatic send_random(input burst_mix_t mix);
		int unsigned       load_pct;
		int unsigned       lim;
		logic              act;
		logic              ins;
		logic [TIME_W-1:0] dur;
		case (mix)
			MIX_FILL:  load_pct = 75;
			MIX_DRAIN: load_pct = 20;
			default:   load_pct = 50;
		endcase
		act = ($urandom_range(99) < load_pct) ? ACT_LOAD : ACT_RUN;
		ins = ($urandom_range(99) < 40);
		// mostly durations near the quantum so processes do complete
		if (sb.quantum == 0)
			lim = 2;
		else if (sb.quantum > 16383)
			lim = 65535;
		else
			lim = 4 * sb.quantum;
		if ($urandom_range(99) < 70)
			dur = TIME_W'($urandom_range(lim, 0));
		else
			dur = TIME_W'($urandom);
		send_word(act, ins, dur);
	endtask

	// one random phase under a fixed quantum
	task automatic run_phase(input logic [TIME_W-1:0] q, input int unsigned phase_no);
		burst_mix_t mix;
		mix = MIX_EVEN;
		write_quantum(q);
		for (int unsigned i = 0; i < PHASE_ITEMS; i++) begin
			if (i % BURST_LEN == 0)
				mix = burst_mix_t'($urandom_range(2));
			// first phase has a stretch with no idling at all
			steady = (phase_no == 0) && (i >= 100) && (i < 300);
			// second phase: receiver stalls while words keep coming
			if (phase_no == 1 && i == 50)
				hold_req = 1'b1;
			// third phase: sender pauses until the pipeline is empty
			if (phase_no == 2 && i == 150)
				wait_results_drained();
			send_random(mix);
		end
		steady = 1'b0;
	endtask

	initial begin
		arst_n                 = 1'b0;
		cfg_we                 = 1'b0;
		cfg_wdata              = '0;
		steady                 = 1'b0;
		hold_req               = 1'b0;
		quanta_used            = 1;
		sched_in.valid         = 1'b0;
		sched_in.action        = ACT_LOAD;
		sched_in.new_valid     = 1'b0;
		sched_in.new_duration  = '0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed part under the reset quantum of 1
		// run on an empty queue, with and without an insert request
		send_word(ACT_RUN, 1'b1, 16'd7);
		send_word(ACT_RUN, 1'b0, 16'd0);
		// zero duration finishes on its first run
		send_word(ACT_LOAD, 1'b0, 16'd0);
		send_word(ACT_RUN, 1'b0, 16'd0);
		// longest duration, then short ones
		send_word(ACT_LOAD, 1'b1, 16'hFFFF);
		send_word(ACT_LOAD, 1'b0, 16'd1);
		send_word(ACT_LOAD, 1'b0, 16'd2);
		// requeue at the tail plus an insert at the head
		send_word(ACT_RUN, 1'b1, 16'h8000);
		send_word(ACT_RUN, 1'b0, 16'd0);
		// fill the ring to the brim
		for (int unsigned i = 0; i < DEPTH - 4; i++)
			send_word(ACT_LOAD, 1'b0, (i % 2) ? 16'hAAAA : 16'h5555);
		// load on a full queue is rejected
		send_word(ACT_LOAD, 1'b0, 16'd3);
		// run that completes and leaves room for the insert
		send_word(ACT_RUN, 1'b1, 16'hFFFF);
		// runs that requeue into a full ring reject their inserts
		send_word(ACT_RUN, 1'b1, 16'hFFFF);
		send_word(ACT_RUN, 1'b1, 16'd0);

		// random phases over the quantum range, extremes included
		run_phase(16'hFFFF, 0);
		run_phase(16'd0, 1);
		run_phase(TIME_W'($urandom_range(40, 2)), 2);
		run_phase(16'd1, 3);
		run_phase(TIME_W'($urandom_range(65535, 1)), 4);
		run_phase(16'd300, 5);

		// let any stray word show up before the verdict
		wait_results_drained();
		repeat (SETTLE_CYCLES * 2) @(negedge clk);

		$display("covered %0d load words and %0d run words (%0d head inserts, %0d completions)",
			sb.n_loads, sb.n_runs, sb.n_inserts, sb.n_done);
		$display("%0d full rejects, %0d empty runs, %0d quantum settings, %0d mismatches",
			sb.n_full, sb.n_empty, quanta_used, sb.failures);
		if (sb.failures == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
